@@ rtl/core/u8san_pkg.sv @@
// UTF-8 sanitiser package: replacement bytes, lead byte bounds and byte
// classification helpers. No dependencies.
package u8san_pkg;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] LEAD_SURR = 8'hED;
  localparam logic [7:0] SEC_A0 = 8'hA0;
  localparam logic [7:0] SEC_90 = 8'h90;
  localparam logic [1:0] CONT_TAG = 2'b10;

  typedef logic [7:0] byte_t;

  // Sequence length fixed by a lead byte; 0 for a byte that cannot start one.
  function automatic logic [2:0] lead_length(input byte_t c);
    logic [2:0] len;
    len = 3'd0;
    if (!c[7]) begin
      len = 3'd1;
    end else if (c >= LEAD2_LO && c <= LEAD2_HI) begin
      len = 3'd2;
    end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
      len = 3'd3;
    end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Second byte range check: overlong, surrogate and above U+10FFFF forms.
  function automatic logic second_ok(input byte_t lead, input byte_t b);
    logic ok;
    ok = 1'b1;
    if (lead == LEAD3_LO && b < SEC_A0) begin
      ok = 1'b0;
    end
    if (lead == LEAD_SURR && b >= SEC_A0) begin
      ok = 1'b0;
    end
    if (lead == LEAD4_LO && b < SEC_90) begin
      ok = 1'b0;
    end
    if (lead == LEAD4_HI && b >= SEC_90) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

@@ rtl/core/utf8_stream_sanitizer_top.sv @@
// UTF-8 stream sanitiser top level: decoder state, run buffer and output
// sequencer. Depends on u8san_pkg.
//
// Latency: the first byte of a request's run is shown the cycle after it is taken.
// Throughput with m_tready high: one request per cycle while each gives at most one
// byte; a run of n bytes (up to 12) is sent one byte per cycle and holds the input
// until its end. The run buffer is the only limit. Empty runs pass without a stall.
// Reset (synchronous, rst high) clears held bytes, lengths, flag and the run buffer.
module utf8_stream_sanitizer_top
  import u8san_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [0] is_replacement, [1] text_changed, [2] last_of_run
  output logic       m_tlast    // text_done
);

  // decoder state
  byte_t      pend [3];
  logic [1:0] pend_cnt;
  logic [2:0] exp_len;
  logic       changed;

  // run buffer
  byte_t      lit [4];
  logic [2:0] rep_left;
  logic [1:0] phase;
  logic [2:0] lit_left;
  logic [1:0] lit_pos;
  logic       run_changed;
  logic       run_end;

  byte_t      pend_next [3];
  logic [1:0] pend_cnt_next;
  logic [2:0] exp_len_next;
  byte_t      lit_next [4];
  logic [2:0] reps;
  logic [2:0] lit_n;

  logic busy, run_last, s_fire, m_fire;

  always_comb begin
    logic       cont;
    logic [2:0] len_c;
    logic       fresh;
    byte_t      c;
    c             = s_tdata;
    cont          = (c[7:6] == CONT_TAG);
    len_c         = lead_length(c);
    fresh         = 1'b0;
    pend_next     = pend;
    pend_cnt_next = pend_cnt;
    exp_len_next  = exp_len;
    reps          = 3'd0;
    lit_n         = 3'd0;
    lit_next[0]   = pend[0];
    lit_next[1]   = pend[1];
    lit_next[2]   = pend[2];
    lit_next[3]   = c;
    if (pend_cnt == 2'd0) begin
      fresh = 1'b1;
    end else if (!(cont && (pend_cnt != 2'd1 || second_ok(pend[0], c)))) begin
      reps          = {1'b0, pend_cnt};
      pend_cnt_next = 2'd0;
      exp_len_next  = 3'd0;
      pend_next     = '{default: 8'h00};
      fresh         = 1'b1;
    end else if (({1'b0, pend_cnt} + 3'd1) >= exp_len) begin
      lit_n           = {1'b0, pend_cnt} + 3'd1;
      lit_next[pend_cnt] = c;
      pend_cnt_next   = 2'd0;
      exp_len_next    = 3'd0;
      pend_next       = '{default: 8'h00};
    end else begin
      pend_next[pend_cnt] = c;
      pend_cnt_next       = pend_cnt + 2'd1;
    end
    if (fresh) begin
      if (len_c == 3'd1) begin
        lit_n       = 3'd1;
        lit_next[0] = c;
      end else if (len_c == 3'd0) begin
        reps = reps + 3'd1;
      end else begin
        pend_next[0]  = c;
        pend_cnt_next = 2'd1;
        exp_len_next  = len_c;
      end
    end
    if (s_tlast) begin
      reps          = reps + {1'b0, pend_cnt_next};
      pend_cnt_next = 2'd0;
      exp_len_next  = 3'd0;
      pend_next     = '{default: 8'h00};
    end
  end

  assign busy     = (rep_left != 3'd0) || (lit_left != 3'd0);
  assign run_last = (rep_left == 3'd1 && phase == 2'd2 && lit_left == 3'd0) ||
                    (rep_left == 3'd0 && lit_left == 3'd1);
  assign s_tready = !busy || (m_tready && run_last);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = busy;
  assign m_fire   = m_tvalid && m_tready;

  always_comb begin
    if (rep_left != 3'd0) begin
      case (phase)
        2'd0:    m_tdata = REPL_B0;
        2'd1:    m_tdata = REPL_B1;
        default: m_tdata = REPL_B2;
      endcase
    end else begin
      m_tdata = lit[lit_pos];
    end
    m_tuser[0] = (rep_left != 3'd0);
    m_tuser[1] = (rep_left != 3'd0) || run_changed;
    m_tuser[2] = run_last;
    m_tlast    = run_last && run_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend        <= '{default: 8'h00};
      pend_cnt    <= 2'd0;
      exp_len     <= 3'd0;
      changed     <= 1'b0;
      rep_left    <= 3'd0;
      phase       <= 2'd0;
      lit_left    <= 3'd0;
      lit_pos     <= 2'd0;
      run_changed <= 1'b0;
      run_end     <= 1'b0;
    end else if (s_fire) begin
      pend        <= pend_next;
      pend_cnt    <= pend_cnt_next;
      exp_len     <= exp_len_next;
      changed     <= s_tlast ? 1'b0 : (changed || reps != 3'd0);
      lit         <= lit_next;
      rep_left    <= reps;
      phase       <= 2'd0;
      lit_left    <= lit_n;
      lit_pos     <= 2'd0;
      run_changed <= changed || reps != 3'd0;
      run_end     <= s_tlast;
    end else if (m_fire) begin
      if (rep_left != 3'd0) begin
        if (phase == 2'd2) begin
          phase    <= 2'd0;
          rep_left <= rep_left - 3'd1;
        end else begin
          phase <= phase + 2'd1;
        end
      end else begin
        lit_left <= lit_left - 3'd1;
        lit_pos  <= lit_pos + 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/u8san_checker.sv @@
// Port-level checks for the UTF-8 sanitiser, bound to its top level.
// Depends on u8san_pkg and utf8_stream_sanitizer_top.
module u8san_checker
  import u8san_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output request changed");

  a_repl_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("replacement byte without sticky flag");

  a_repl_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      (m_tdata == REPL_B0 || m_tdata == REPL_B1 || m_tdata == REPL_B2))
    else $error("bad replacement byte");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[2])
    else $error("text end not on last byte of run");

endmodule

bind utf8_stream_sanitizer_top u8san_checker u_u8san_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
